// ----- rtl/tri_pkg.sv -----
// Shared types, stage numbering and Q16.16 arithmetic helpers for the
// ray/triangle intersection pipeline. No dependencies.
package tri_pkg;

    localparam int unsigned ADDR_W   = 6;
    localparam int unsigned DATA_W   = 64;
    localparam int unsigned WORD_W   = 32;
    localparam int unsigned PROD_W   = 48;
    localparam int unsigned SUM_W    = 50;
    localparam int unsigned DIVD_W   = 48;
    localparam int unsigned DIV_BITS = 4;
    localparam int unsigned DIV_STAGES = DIVD_W / DIV_BITS;

    localparam logic [2:0] REG_V0_XY    = 3'd0;
    localparam logic [2:0] REG_V0Z_V1X  = 3'd1;
    localparam logic [2:0] REG_V1_YZ    = 3'd2;
    localparam logic [2:0] REG_V2_XY    = 3'd3;
    localparam logic [2:0] REG_V2Z_NX   = 3'd4;
    localparam logic [2:0] REG_N_YZ     = 3'd5;
    localparam logic [2:0] REG_EYE_XY   = 3'd6;
    localparam logic [2:0] REG_EYE_Z    = 3'd7;

    localparam logic signed [31:0] EPS_RAW  = 32'sd7;
    localparam logic signed [31:0] WORD_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;

    localparam int ST_PMUL  = 0;
    localparam int ST_P     = 1;
    localparam int ST_DMUL  = 2;
    localparam int ST_DET   = 3;
    localparam int ST_UMUL  = 4;
    localparam int ST_U     = 5;
    localparam int ST_VMUL  = 6;
    localparam int ST_V     = 7;
    localparam int ST_DIV0  = 8;
    localparam int ST_TQ    = ST_DIV0 + DIV_STAGES;
    localparam int ST_PTMUL = ST_TQ + 1;
    localparam int ST_PT    = ST_TQ + 2;
    localparam int ST_W     = ST_TQ + 3;
    localparam int ST_NMUL  = ST_TQ + 4;
    localparam int ST_OUT   = ST_TQ + 5;
    localparam int NUM_STAGES = ST_OUT + 1;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } vec_t;

    typedef struct packed {
        vec_t v0;
        vec_t e1;
        vec_t e2;
        vec_t nrm;
        vec_t eye;
    } cfg_t;

    typedef struct packed {
        vec_t org;
        vec_t dir;
        vec_t p;
        vec_t tv;
        vec_t tvn;
        vec_t q;
        vec_t pt;
        vec_t w;
        vec_t srf;
        logic [8:0][PROD_W-1:0] m;
        logic signed [31:0] det;
        logic signed [31:0] u;
        logic signed [31:0] v;
        logic signed [31:0] num;
        logic signed [31:0] tq;
        logic [31:0] rem;
        logic [DIVD_W-1:0] dq;
        logic ok;
        logic neg;
    } pipe_t;

    function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
        if (v > 50'sd2147483647) return WORD_MAX;
        if (v < -50'sd2147483648) return WORD_MIN;
        return v[31:0];
    endfunction

    function automatic logic signed [SUM_W-1:0] ext32(input logic signed [31:0] a);
        return {{(SUM_W-32){a[31]}}, a};
    endfunction

    function automatic logic signed [SUM_W-1:0] ext48(input logic [PROD_W-1:0] a);
        return {{(SUM_W-PROD_W){a[PROD_W-1]}}, a};
    endfunction

    // exact product, floored by 2^16
    function automatic logic [PROD_W-1:0] fmul(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
        logic signed [63:0] pr;
        pr = a * b;
        return pr[63:16];
    endfunction

    function automatic logic signed [31:0] dot3(input logic [PROD_W-1:0] a,
                                                input logic [PROD_W-1:0] b,
                                                input logic [PROD_W-1:0] c);
        return sat32(ext48(a) + ext48(b) + ext48(c));
    endfunction

    function automatic logic signed [31:0] dif(input logic [PROD_W-1:0] a,
                                               input logic [PROD_W-1:0] b);
        return sat32(ext48(a) - ext48(b));
    endfunction

    function automatic vec_t vsub(input vec_t a, input vec_t b);
        vec_t r;
        r.x = sat32(ext32(a.x) - ext32(b.x));
        r.y = sat32(ext32(a.y) - ext32(b.y));
        r.z = sat32(ext32(a.z) - ext32(b.z));
        return r;
    endfunction

    function automatic logic signed [31:0] neg32(input logic signed [31:0] a);
        return sat32(-ext32(a));
    endfunction

    function automatic pipe_t stage_fn(input int k, input pipe_t d, input cfg_t c);
        pipe_t r;
        logic signed [31:0] dt;
        logic signed [32:0] uv;
        logic signed [32:0] mag;
        logic [32:0] tr;
        logic flip;
        r = d;
        case (k)
            ST_PMUL: begin
                r.m[0] = fmul(d.dir.y, c.e2.z);
                r.m[1] = fmul(d.dir.z, c.e2.y);
                r.m[2] = fmul(d.dir.z, c.e2.x);
                r.m[3] = fmul(d.dir.x, c.e2.z);
                r.m[4] = fmul(d.dir.x, c.e2.y);
                r.m[5] = fmul(d.dir.y, c.e2.x);
            end
            ST_P: begin
                r.p.x = dif(d.m[0], d.m[1]);
                r.p.y = dif(d.m[2], d.m[3]);
                r.p.z = dif(d.m[4], d.m[5]);
            end
            ST_DMUL: begin
                r.m[0] = fmul(c.e1.x, d.p.x);
                r.m[1] = fmul(c.e1.y, d.p.y);
                r.m[2] = fmul(c.e1.z, d.p.z);
                r.tv   = vsub(d.org, c.v0);
                r.tvn  = vsub(c.v0, d.org);
            end
            ST_DET: begin
                dt = dot3(d.m[0], d.m[1], d.m[2]);
                if (dt > 32'sd0) begin
                    r.det = dt;
                end else begin
                    r.det = neg32(dt);
                    r.tv  = d.tvn;
                end
            end
            ST_UMUL: begin
                r.m[0] = fmul(d.tv.x, d.p.x);
                r.m[1] = fmul(d.tv.y, d.p.y);
                r.m[2] = fmul(d.tv.z, d.p.z);
                r.m[3] = fmul(d.tv.y, c.e1.z);
                r.m[4] = fmul(d.tv.z, c.e1.y);
                r.m[5] = fmul(d.tv.z, c.e1.x);
                r.m[6] = fmul(d.tv.x, c.e1.z);
                r.m[7] = fmul(d.tv.x, c.e1.y);
                r.m[8] = fmul(d.tv.y, c.e1.x);
            end
            ST_U: begin
                r.u   = dot3(d.m[0], d.m[1], d.m[2]);
                r.q.x = dif(d.m[3], d.m[4]);
                r.q.y = dif(d.m[5], d.m[6]);
                r.q.z = dif(d.m[7], d.m[8]);
                r.ok  = (d.det >= EPS_RAW) && (r.u >= 32'sd0) && (r.u <= d.det);
            end
            ST_VMUL: begin
                r.m[0] = fmul(d.dir.x, d.q.x);
                r.m[1] = fmul(d.dir.y, d.q.y);
                r.m[2] = fmul(d.dir.z, d.q.z);
                r.m[3] = fmul(c.e2.x, d.q.x);
                r.m[4] = fmul(c.e2.y, d.q.y);
                r.m[5] = fmul(c.e2.z, d.q.z);
            end
            ST_V: begin
                r.v   = dot3(d.m[0], d.m[1], d.m[2]);
                r.num = dot3(d.m[3], d.m[4], d.m[5]);
                uv    = {d.u[31], d.u} + {r.v[31], r.v};
                r.ok  = d.ok && (r.v >= 32'sd0) && (uv <= {d.det[31], d.det});
                r.neg = r.num[31];
                mag   = r.neg ? -{r.num[31], r.num} : {r.num[31], r.num};
                r.dq  = {mag[31:0], 16'd0};
                r.rem = '0;
            end
            ST_TQ: begin
                if (!d.neg) begin
                    r.tq = (|d.dq[DIVD_W-1:31]) ? WORD_MAX : d.dq[31:0];
                end else if (d.dq > 48'd2147483648) begin
                    r.tq = WORD_MIN;
                end else begin
                    r.tq = -d.dq[31:0];
                end
            end
            ST_PTMUL: begin
                r.m[0] = fmul(d.dir.x, d.tq);
                r.m[1] = fmul(d.dir.y, d.tq);
                r.m[2] = fmul(d.dir.z, d.tq);
            end
            ST_PT: begin
                r.pt.x = sat32(ext32(d.org.x) + ext48(d.m[0]));
                r.pt.y = sat32(ext32(d.org.y) + ext48(d.m[1]));
                r.pt.z = sat32(ext32(d.org.z) + ext48(d.m[2]));
            end
            ST_W: begin
                r.w = vsub(c.eye, d.pt);
            end
            ST_NMUL: begin
                r.m[0] = fmul(d.w.x, c.nrm.x);
                r.m[1] = fmul(d.w.y, c.nrm.y);
                r.m[2] = fmul(d.w.z, c.nrm.z);
            end
            ST_OUT: begin
                flip = dot3(d.m[0], d.m[1], d.m[2]) < 32'sd0;
                if (flip) begin
                    r.srf.x = neg32(c.nrm.x);
                    r.srf.y = neg32(c.nrm.y);
                    r.srf.z = neg32(c.nrm.z);
                end else begin
                    r.srf = c.nrm;
                end
                if (!d.ok) begin
                    r.tq  = '0;
                    r.pt  = '0;
                    r.srf = '0;
                end
            end
            default: begin
                // restoring divide, DIV_BITS quotient bits per stage
                for (int i = 0; i < DIV_BITS; i++) begin
                    tr = {r.rem, r.dq[DIVD_W-1]};
                    r.dq = {r.dq[DIVD_W-2:0], 1'b0};
                    if (tr >= {1'b0, d.det}) begin
                        tr = tr - {1'b0, d.det};
                        r.dq[0] = 1'b1;
                    end
                    r.rem = tr[31:0];
                end
            end
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/triangle_ray_intersection.sv -----
// Top level of the Moller-Trumbore ray/triangle intersection pipeline.
// Depends on tri_pkg, tri_cfg and tri_stage.
//
// One ray item is accepted every cycle unless back-pressure from m_ready stalls
// the pipeline. Each ray passes through edge products and sums, restoring division
// at four quotient bits per stage, then hit point and normal facing. Every stage
// holds its item under back-pressure, so bubbles are squeezed out. Configuration
// reaches the datapath through the cfg_reg register in tri_cfg.
module triangle_ray_intersection import tri_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ADDR_W-1:0]        paddr,
    input  logic [DATA_W-1:0]        pwdata,
    output logic [DATA_W-1:0]        prdata,
    output logic                     pready,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic signed [WORD_W-1:0] s_origin_x,
    input  logic signed [WORD_W-1:0] s_origin_y,
    input  logic signed [WORD_W-1:0] s_origin_z,
    input  logic signed [WORD_W-1:0] s_direction_x,
    input  logic signed [WORD_W-1:0] s_direction_y,
    input  logic signed [WORD_W-1:0] s_direction_z,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic                     m_hit,
    output logic signed [WORD_W-1:0] m_hit_distance,
    output logic signed [WORD_W-1:0] m_hit_point_x,
    output logic signed [WORD_W-1:0] m_hit_point_y,
    output logic signed [WORD_W-1:0] m_hit_point_z,
    output logic signed [WORD_W-1:0] m_surface_x,
    output logic signed [WORD_W-1:0] m_surface_y,
    output logic signed [WORD_W-1:0] m_surface_z
);

    cfg_t  cfg;
    pipe_t data [NUM_STAGES+1];
    logic  vld  [NUM_STAGES+1];
    logic  rdy  [NUM_STAGES+1];

    assign pready = 1'b1;

    tri_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    always_comb begin
        data[0]       = '0;
        data[0].org.x = s_origin_x;
        data[0].org.y = s_origin_y;
        data[0].org.z = s_origin_z;
        data[0].dir.x = s_direction_x;
        data[0].dir.y = s_direction_y;
        data[0].dir.z = s_direction_z;
    end

    assign vld[0]  = s_valid;
    assign s_ready = rdy[0];

    for (genvar k = 0; k < NUM_STAGES; k++) begin : g_stage
        tri_stage #(.STAGE(k)) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .cfg       (cfg),
            .in_valid  (vld[k]),
            .in_ready  (rdy[k]),
            .in_data   (data[k]),
            .out_valid (vld[k+1]),
            .out_ready (rdy[k+1]),
            .out_data  (data[k+1])
        );
    end

    assign rdy[NUM_STAGES] = m_ready;
    assign m_valid         = vld[NUM_STAGES];
    assign m_hit           = data[NUM_STAGES].ok;
    assign m_hit_distance  = data[NUM_STAGES].tq;
    assign m_hit_point_x   = data[NUM_STAGES].pt.x;
    assign m_hit_point_y   = data[NUM_STAGES].pt.y;
    assign m_hit_point_z   = data[NUM_STAGES].pt.z;
    assign m_surface_x     = data[NUM_STAGES].srf.x;
    assign m_surface_y     = data[NUM_STAGES].srf.y;
    assign m_surface_z     = data[NUM_STAGES].srf.z;

endmodule

// ----- rtl/tri_cfg.sv -----
// APB register file holding the triangle, face normal and eye position.
// Also derives edge vectors e1 and e2 and registers them with the rest. Depends on tri_pkg.
module tri_cfg import tri_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output cfg_t              cfg
);

    logic [7:0][DATA_W-1:0] regs_reg;
    cfg_t raw;
    cfg_t cfg_reg;
    logic [2:0] idx;

    assign idx = paddr[ADDR_W-1:3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            regs_reg <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (idx)
                REG_EYE_Z: regs_reg[idx] <= {32'd0, pwdata[31:0]};
                default:   regs_reg[idx] <= pwdata;
            endcase
        end
    end

    assign prdata = regs_reg[idx];

    always_comb begin
        raw       = '0;
        raw.v0.x  = regs_reg[REG_V0_XY][63:32];
        raw.v0.y  = regs_reg[REG_V0_XY][31:0];
        raw.v0.z  = regs_reg[REG_V0Z_V1X][63:32];
        raw.nrm.x = regs_reg[REG_V2Z_NX][31:0];
        raw.nrm.y = regs_reg[REG_N_YZ][63:32];
        raw.nrm.z = regs_reg[REG_N_YZ][31:0];
        raw.eye.x = regs_reg[REG_EYE_XY][63:32];
        raw.eye.y = regs_reg[REG_EYE_XY][31:0];
        raw.eye.z = regs_reg[REG_EYE_Z][31:0];
        raw.e1    = vsub('{x: regs_reg[REG_V0Z_V1X][31:0], y: regs_reg[REG_V1_YZ][63:32],
                           z: regs_reg[REG_V1_YZ][31:0]}, raw.v0);
        raw.e2    = vsub('{x: regs_reg[REG_V2_XY][63:32], y: regs_reg[REG_V2_XY][31:0],
                           z: regs_reg[REG_V2Z_NX][63:32]}, raw.v0);
    end

    always_ff @(posedge aclk) begin
        cfg_reg <= raw;
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/tri_stage.sv -----
// One register stage of the intersection pipeline with valid/ready flow.
// The work done is chosen by STAGE from stage_fn in tri_pkg.
module tri_stage import tri_pkg::*; #(
    parameter int STAGE = 0
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  cfg_t  cfg,
    input  logic  in_valid,
    output logic  in_ready,
    input  pipe_t in_data,
    output logic  out_valid,
    input  logic  out_ready,
    output pipe_t out_data
);

    logic  valid_reg;
    pipe_t data_reg;

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= stage_fn(STAGE, in_data, cfg);
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ----- rtl/tri_checker.sv -----
// Port-level checks for triangle_ray_intersection, bound to the top level.
// Depends on the top level's port names.
module tri_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        pready,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_hit,
    input logic [31:0] m_hit_distance,
    input logic [31:0] m_hit_point_x,
    input logic [31:0] m_surface_x,
    input logic [31:0] m_surface_y,
    input logic [31:0] m_surface_z
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hit) && $stable(m_hit_distance))
        else $error("result item changed while stalled");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_hit |-> m_hit_distance == 32'd0 && m_hit_point_x == 32'd0 &&
            m_surface_x == 32'd0 && m_surface_y == 32'd0 && m_surface_z == 32'd0)
        else $error("miss item carries nonzero values");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without a blocked result");

    a_reset_empty: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid)
        else $error("result valid straight after reset");

    a_pready: assert property (@(posedge aclk) disable iff (!aresetn) pready)
        else $error("pready dropped");

endmodule

bind triangle_ray_intersection tri_checker u_tri_checker (.*);

// ----- test/tb_triangle_ray_intersection.sv -----
// Self-checking testbench for triangle_ray_intersection: APB register setup,
// random ray items with idling on both sides, predicted results compared per field.
// Depends on tri_pkg and the triangle_ray_intersection RTL.
module tb_triangle_ray_intersection;
    import tri_pkg::*;

    typedef logic [5:0][31:0] ray_t;
    typedef logic [7:0][31:0] res_t;
    typedef longint vec3_t [3];

    logic aclk, aresetn;
    logic psel, penable, pwrite, pready;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata, prdata;
    logic s_valid, s_ready, m_valid, m_ready, m_hit;
    logic signed [31:0] s_origin_x, s_origin_y, s_origin_z;
    logic signed [31:0] s_direction_x, s_direction_y, s_direction_z;
    logic signed [31:0] m_hit_distance, m_hit_point_x, m_hit_point_y, m_hit_point_z;
    logic signed [31:0] m_surface_x, m_surface_y, m_surface_z;

    ray_t  ray_pending[$];
    res_t  hits_due[$];
    logic [63:0] tri_regs[8];
    ray_t  ray_cur;
    logic  ray_taken, res_got, burst;
    int    send_gap, recv_gap, errors;
    string field_name[8] = '{"hit", "hit_distance", "hit_point_x", "hit_point_y",
                             "hit_point_z", "surface_x", "surface_y", "surface_z"};

    triangle_ray_intersection i_dut (.*);

    initial begin
        aclk = 0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic longint sat(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint s32(logic [31:0] w);
        return longint'(signed'(w));
    endfunction

    function automatic longint qmul(longint a, longint b);
        return (a * b) >>> 16;
    endfunction

    function automatic vec3_t vdiff(vec3_t a, vec3_t b);
        vec3_t r;
        for (int i = 0; i < 3; i++) r[i] = sat(a[i] - b[i]);
        return r;
    endfunction

    function automatic longint vdot(vec3_t a, vec3_t b);
        return sat(qmul(a[0], b[0]) + qmul(a[1], b[1]) + qmul(a[2], b[2]));
    endfunction

    function automatic vec3_t vcross(vec3_t a, vec3_t b);
        vec3_t r;
        r[0] = sat(qmul(a[1], b[2]) - qmul(a[2], b[1]));
        r[1] = sat(qmul(a[2], b[0]) - qmul(a[0], b[2]));
        r[2] = sat(qmul(a[0], b[1]) - qmul(a[1], b[0]));
        return r;
    endfunction

    function automatic res_t trace_ray(ray_t r);
        vec3_t v0, v1, v2, nrm, eye, org, dir, e1, e2, p, tv, q, pt, w;
        longint det, u, v, num, tq;
        res_t res;
        res = '0;
        v0  = '{s32(tri_regs[REG_V0_XY][63:32]), s32(tri_regs[REG_V0_XY][31:0]),
                s32(tri_regs[REG_V0Z_V1X][63:32])};
        v1  = '{s32(tri_regs[REG_V0Z_V1X][31:0]), s32(tri_regs[REG_V1_YZ][63:32]),
                s32(tri_regs[REG_V1_YZ][31:0])};
        v2  = '{s32(tri_regs[REG_V2_XY][63:32]), s32(tri_regs[REG_V2_XY][31:0]),
                s32(tri_regs[REG_V2Z_NX][63:32])};
        nrm = '{s32(tri_regs[REG_V2Z_NX][31:0]), s32(tri_regs[REG_N_YZ][63:32]),
                s32(tri_regs[REG_N_YZ][31:0])};
        eye = '{s32(tri_regs[REG_EYE_XY][63:32]), s32(tri_regs[REG_EYE_XY][31:0]),
                s32(tri_regs[REG_EYE_Z][31:0])};
        org = '{s32(r[0]), s32(r[1]), s32(r[2])};
        dir = '{s32(r[3]), s32(r[4]), s32(r[5])};
        e1 = vdiff(v1, v0);
        e2 = vdiff(v2, v0);
        p = vcross(dir, e2);
        det = vdot(e1, p);
        if (det > 0) begin
            tv = vdiff(org, v0);
        end else begin
            tv = vdiff(v0, org);
            det = sat(-det);
        end
        if (det < 7) return res;
        u = vdot(tv, p);
        if (u < 0 || u > det) return res;
        q = vcross(tv, e1);
        v = vdot(dir, q);
        if (v < 0 || u + v > det) return res;
        num = vdot(e2, q);
        tq = sat((num * 65536) / det);
        for (int i = 0; i < 3; i++) pt[i] = sat(org[i] + qmul(dir[i], tq));
        w = vdiff(eye, pt);
        if (vdot(w, nrm) < 0)
            for (int i = 0; i < 3; i++) nrm[i] = sat(-nrm[i]);
        res[0] = 1;
        res[1] = tq[31:0];
        for (int i = 0; i < 3; i++) begin
            res[2+i] = pt[i][31:0];
            res[5+i] = nrm[i][31:0];
        end
        return res;
    endfunction

    // send side
    always @(negedge aclk) begin
        logic v;
        v = s_valid;
        if (!aresetn) begin
            v = 0;
        end else if (!s_valid || ray_taken) begin
            v = 0;
            if (ray_taken) send_gap = burst ? 0 : $urandom_range(0, 10);
            if (send_gap > 0) begin
                send_gap--;
            end else if (ray_pending.size() > 0) begin
                ray_cur = ray_pending.pop_front();
                {s_direction_z, s_direction_y, s_direction_x,
                 s_origin_z, s_origin_y, s_origin_x} <= ray_cur;
                v = 1;
            end
        end
        ray_taken <= 0;
        s_valid <= v;
    end

    // receive side
    always @(negedge aclk) begin
        if (res_got) recv_gap = burst ? 0 : $urandom_range(0, 10);
        res_got <= 0;
        if (recv_gap > 0) begin
            recv_gap--;
            m_ready <= 0;
        end else begin
            m_ready <= 1;
        end
    end

    always @(posedge aclk) begin
        res_t act, exp_res;
        if (aresetn && s_valid && s_ready) begin
            hits_due.push_back(trace_ray(ray_cur));
            ray_taken <= 1;
        end
        if (aresetn && m_valid && m_ready) begin
            res_got <= 1;
            act = {m_surface_z, m_surface_y, m_surface_x, m_hit_point_z, m_hit_point_y,
                   m_hit_point_x, m_hit_distance, 31'd0, m_hit};
            if (hits_due.size() == 0) begin
                $display("%0t: unexpected item, hit %0d", $time, m_hit);
                errors++;
            end else begin
                exp_res = hits_due.pop_front();
                for (int i = 0; i < 8; i++)
                    if (act[i] !== exp_res[i]) begin
                        $display("%0t: %s expected %h actual %h", $time, field_name[i],
                                 exp_res[i], act[i]);
                        errors++;
                    end
            end
        end
    end

    task automatic reg_write(logic [2:0] idx, logic [63:0] val);
        @(negedge aclk);
        psel <= 1; pwrite <= 1; penable <= 0;
        paddr <= {idx, 3'b000}; pwdata <= val;
        @(negedge aclk);
        penable <= 1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        tri_regs[idx] = (idx == REG_EYE_Z) ? {32'd0, val[31:0]} : val;
        @(negedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    task automatic drain;
        while (ray_pending.size() > 0 || s_valid || hits_due.size() > 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic set_triangle(longint v[5][3], longint eye[3]);
        reg_write(REG_V0_XY,   {v[0][0][31:0], v[0][1][31:0]});
        reg_write(REG_V0Z_V1X, {v[0][2][31:0], v[1][0][31:0]});
        reg_write(REG_V1_YZ,   {v[1][1][31:0], v[1][2][31:0]});
        reg_write(REG_V2_XY,   {v[2][0][31:0], v[2][1][31:0]});
        reg_write(REG_V2Z_NX,  {v[2][2][31:0], v[3][0][31:0]});
        reg_write(REG_N_YZ,    {v[3][1][31:0], v[3][2][31:0]});
        reg_write(REG_EYE_XY,  {eye[0][31:0], eye[1][31:0]});
        reg_write(REG_EYE_Z,   {32'd0, eye[2][31:0]});
    endtask

    function automatic longint srand(int bits);
        return longint'($urandom_range(0, (1 << bits) - 1)) - (longint'(1) << (bits - 1));
    endfunction

    function automatic ray_t noise_ray();
        ray_t r;
        for (int i = 0; i < 6; i++)
            case ($urandom_range(0, 5))
                0: r[i] = 32'h7fff_ffff;
                1: r[i] = 32'h8000_0000;
                2: r[i] = 32'(srand(18));
                default: r[i] = $urandom;
            endcase
        return r;
    endfunction

    // ray aimed at a point of the current triangle (or just beyond an edge)
    function automatic ray_t aimed_ray();
        ray_t r;
        longint a, b, tgt, o, d;
        int sh;
        a = $urandom_range(0, 70000);
        b = $urandom_range(0, int'(70000 - a));
        sh = $urandom_range(0, 2);
        for (int i = 0; i < 3; i++) begin
            longint v0, v1, v2;
            v0 = s32(i == 0 ? tri_regs[REG_V0_XY][63:32] :
                     i == 1 ? tri_regs[REG_V0_XY][31:0] : tri_regs[REG_V0Z_V1X][63:32]);
            v1 = s32(i == 0 ? tri_regs[REG_V0Z_V1X][31:0] :
                     i == 1 ? tri_regs[REG_V1_YZ][63:32] : tri_regs[REG_V1_YZ][31:0]);
            v2 = s32(i == 0 ? tri_regs[REG_V2_XY][63:32] :
                     i == 1 ? tri_regs[REG_V2_XY][31:0] : tri_regs[REG_V2Z_NX][63:32]);
            tgt = v0 + (((v1 - v0) * a + (v2 - v0) * b) >>> 16);
            o = srand(24);
            d = (tgt - o) >>> sh;
            r[i] = 32'(sat(o));
            r[3+i] = 32'(sat(d));
        end
        return r;
    endfunction

    function automatic ray_t mk_ray(longint ox, longint oy, longint oz,
                                    longint dx, longint dy, longint dz);
        ray_t r;
        r = {dz[31:0], dy[31:0], dx[31:0], oz[31:0], oy[31:0], ox[31:0]};
        return r;
    endfunction

    initial begin
        longint tv[5][3];
        longint eye[3];
        localparam longint ONE = 65536;
        errors = 0; burst = 0; send_gap = 0; recv_gap = 0;
        ray_taken = 0; res_got = 0;
        aresetn = 0; s_valid = 0; m_ready = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        {s_origin_x, s_origin_y, s_origin_z, s_direction_x, s_direction_y, s_direction_z} = '0;
        for (int i = 0; i < 8; i++) tri_regs[i] = '0;
        repeat (11) @(posedge aclk);
        @(negedge aclk) aresetn <= 1;

        // degenerate triangle after reset
        ray_pending.push_back(mk_ray(0, 0, ONE, 0, 0, -ONE));
        for (int i = 0; i < 5; i++) ray_pending.push_back(noise_ray());
        drain();

        // unit triangle in the z = 0 plane, normal +z, eye above
        tv = '{'{0, 0, 0}, '{ONE, 0, 0}, '{0, ONE, 0}, '{0, 0, ONE}, '{0, 0, 0}};
        eye = '{0, 0, 5 * ONE};
        set_triangle(tv, eye);
        ray_pending.push_back(mk_ray(ONE / 4, ONE / 4, 2 * ONE, 0, 0, -ONE));
        ray_pending.push_back(mk_ray(ONE / 4, ONE / 4, 2 * ONE, 0, 0, ONE));
        ray_pending.push_back(mk_ray(ONE / 4, ONE / 4, -3 * ONE, 0, 0, ONE));
        ray_pending.push_back(mk_ray(ONE / 4, ONE / 4, ONE, ONE, 0, 0));
        ray_pending.push_back(mk_ray(0, 0, ONE, 0, 0, -ONE));
        ray_pending.push_back(mk_ray(ONE, 0, ONE, 0, 0, -ONE));
        ray_pending.push_back(mk_ray(0, ONE, ONE, 0, 0, -ONE));
        ray_pending.push_back(mk_ray(ONE / 2, ONE / 2, ONE, 0, 0, -ONE));
        ray_pending.push_back(mk_ray(ONE, ONE, ONE, 0, 0, -ONE));
        ray_pending.push_back(mk_ray(-1, ONE / 4, ONE, 0, 0, -ONE));
        ray_pending.push_back(mk_ray(ONE / 4, ONE / 4, ONE, 0, 0, -6));
        ray_pending.push_back(mk_ray(ONE / 4, ONE / 4, ONE, 0, 0, -7));
        ray_pending.push_back(mk_ray(ONE / 4, ONE / 4, 32'h7fff_ffff, 0, 0, -1));
        ray_pending.push_back(mk_ray(0, 0, 0, 0, 0, 0));
        ray_pending.push_back(mk_ray(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                                     32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
        ray_pending.push_back(mk_ray(-2147483648, -2147483648, -2147483648,
                                     -2147483648, -2147483648, -2147483648));
        ray_pending.push_back(mk_ray(ONE / 8, ONE / 8, 2 * ONE, 0, 0, -2147483648));
        drain();

        // normal facing away from the eye: flipped on a hit
        tv[3] = '{0, 0, -ONE};
        set_triangle(tv, eye);
        ray_pending.push_back(mk_ray(ONE / 4, ONE / 4, 2 * ONE, 0, 0, -ONE));
        ray_pending.push_back(mk_ray(ONE / 4, ONE / 4, -2 * ONE, 0, 0, ONE));
        ray_pending.push_back(mk_ray(ONE / 4, ONE / 4, 2 * ONE, 0, 0, -2 * ONE));
        drain();

        // extreme words everywhere
        tv = '{'{2147483647, -2147483648, 2147483647}, '{-2147483648, 2147483647, -2147483648},
               '{2147483647, 2147483647, -2147483648}, '{-2147483648, -2147483648, 2147483647},
               '{0, 0, 0}};
        eye = '{-2147483648, 2147483647, -2147483648};
        set_triangle(tv, eye);
        for (int i = 0; i < 10; i++) ray_pending.push_back(noise_ray());
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            for (int k = 0; k < 3; k++)
                for (int i = 0; i < 3; i++) tv[k][i] = srand(ph == 5 ? 32 : 23);
            for (int i = 0; i < 3; i++) begin
                tv[3][i] = srand(ph == 4 ? 32 : 18);
                eye[i] = srand(24);
            end
            set_triangle(tv, eye);
            burst = (ph == 2);
            for (int n = 0; n < 88; n++)
                ray_pending.push_back($urandom_range(0, 3) == 0 ? noise_ray() : aimed_ray());
            drain();
        end

        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
